@@ rtl/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants and the arctangent table for the quaternion to
// Euler angle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

  // field widths
  localparam int QW = 16;            // quaternion component, Q2.14
  localparam int AW = 16;            // angle out, Q3.13

  // internal widths
  localparam int PW   = 34;          // products summed and doubled, Q6.28
  localparam int CW   = 38;          // cordic x / y datapath
  localparam int ZW   = 33;          // cordic angle accumulator, Q30
  localparam int TW   = 30;          // arctangent table entry
  localparam int HW   = 14;          // half of the sine magnitude
  localparam int MW   = 2 * HW;      // sine magnitude below one
  localparam int SQW  = 58;          // square root remainder / root
  localparam int RW   = MW + 1;      // root and reduced sine width

  localparam int SQRT_STAGES = MW + 1;         // one root bit per stage
  localparam int ISQ_LAT     = SQRT_STAGES + 2; // plus square and subtract

  localparam int ATAN_LEN         = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic signed [PW-1:0] ONE_Q28     = PW'(268435456);
  localparam logic signed [PW-1:0] NEG_ONE_Q28 = -PW'(268435456);
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(1686629713);
  localparam logic signed [AW-1:0] HALF_PI_Q13 = AW'(12868);
  localparam logic        [AW-1:0] PI_Q13      = AW'(25736);

  // atan(2^-i) in Q30, truncated
  function automatic logic [TW-1:0] atan_q30(input int idx);
    logic [TW-1:0] v;
    case (idx)
      0:  v = TW'(843314856);
      1:  v = TW'(497837829);
      2:  v = TW'(263043836);
      3:  v = TW'(133525158);
      4:  v = TW'(67021686);
      5:  v = TW'(33543515);
      6:  v = TW'(16775850);
      7:  v = TW'(8388437);
      8:  v = TW'(4194282);
      9:  v = TW'(2097149);
      10: v = TW'(1048575);
      11: v = TW'(524287);
      12: v = TW'(262143);
      13: v = TW'(131071);
      14: v = TW'(65535);
      15: v = TW'(32767);
      16: v = TW'(16383);
      17: v = TW'(8191);
      18: v = TW'(4095);
      19: v = TW'(2047);
      20: v = TW'(1023);
      21: v = TW'(511);
      22: v = TW'(255);
      23: v = TW'(127);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/quaternion_to_euler_angles_unit.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit
// Attitude quaternion (Q2.14) to vehicle-frame Euler angles (Q3.13 radians).
// ----------------------------------------------------------------------------
// One request enters per clock while in_stall is low, and one result
// leaves per request, in order. A request passes the products and sums,
// the pitch cosine (square, subtract, one root bit per stage), the cordic
// pre-rotation, one cordic iteration per stage (steps above 24 count as
// 24), rounding, and the output register. The whole pipeline advances
// together; it holds while a finished result waits under out_stall, and
// in_stall follows it.
// Roll and yaw run their cordics early and wait in a delay line for pitch.
// Output: frame_roll = -pitch, frame_pitch = roll, heading = yaw; when the
// pitch sine reaches magnitude one, pitch is forced to +-pi/2 and
// pitch_clamped is set.
`default_nettype none

module quaternion_to_euler_angles_unit import qte_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [QW-1:0] in_quat_w,
  input  logic signed [QW-1:0] in_quat_x,
  input  logic signed [QW-1:0] in_quat_y,
  input  logic signed [QW-1:0] in_quat_z,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [AW-1:0] out_frame_roll,
  output logic signed [AW-1:0] out_frame_pitch,
  output logic signed [AW-1:0] out_heading,
  output logic                 out_pitch_clamped
);

  // cordic: pre-rotation, iterations, rounding
  localparam int NIT  = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int CLAT = NIT + 2;

  // pipeline advance: open unless a result sits unclaimed
  logic en;

  logic                 f_vld;
  logic signed [PW-1:0] sr, cr, sy, cy, sp;

  logic                 q_vld, q_clamp, q_neg;
  logic        [RW-1:0] q_c;
  logic signed [RW-1:0] q_sp;

  logic signed [AW-1:0] roll_a, yaw_a, pitch_a;
  logic [2*AW-1:0]      ry_d;
  logic [2:0]           flags_d;

  logic                 out_valid_r;
  logic signed [AW-1:0] frame_roll_r, frame_pitch_r, heading_r;
  logic                 clamped_r;
  logic signed [AW-1:0] frame_roll_nxt;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // products and sine / cosine terms
  qte_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .w       (in_quat_w),
    .x       (in_quat_x),
    .y       (in_quat_y),
    .z       (in_quat_z),
    .out_vld (f_vld),
    .sr      (sr),
    .cr      (cr),
    .sy      (sy),
    .cy      (cy),
    .sp      (sp)
  );

  // roll and yaw angles
  qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk     (clk),
    .en      (en),
    .y_in    (CW'(sr)),
    .x_in    (CW'(cr)),
    .ang_out (roll_a)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk     (clk),
    .en      (en),
    .y_in    (CW'(sy)),
    .x_in    (CW'(cy)),
    .ang_out (yaw_a)
  );

  // hold roll and yaw while the pitch cosine is worked out
  qte_delay #(.WIDTH(2 * AW), .DEPTH(ISQ_LAT)) u_ry_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d_in  ({roll_a, yaw_a}),
    .d_out (ry_d)
  );

  // pitch cosine sqrt(1 - s^2)
  qte_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (f_vld),
    .sp_in     (sp),
    .out_vld   (q_vld),
    .c_out     (q_c),
    .sp_out    (q_sp),
    .clamp_out (q_clamp),
    .neg_out   (q_neg)
  );

  // pitch angle as atan2(s, sqrt(1 - s^2))
  qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk     (clk),
    .en      (en),
    .y_in    (CW'(q_sp)),
    .x_in    ($signed({{(CW-RW){1'b0}}, q_c})),
    .ang_out (pitch_a)
  );

  // valid and saturation flags ride beside the pitch cordic
  qte_delay #(.WIDTH(3), .DEPTH(CLAT)) u_flag_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d_in  ({q_vld, q_clamp, q_neg}),
    .d_out (flags_d)
  );

  // saturated pitch is +-pi/2 with the sign of s, so -pitch is the opposite
  always_comb begin
    if (flags_d[1]) begin
      frame_roll_nxt = flags_d[0] ? HALF_PI_Q13 : -HALF_PI_Q13;
    end else begin
      frame_roll_nxt = -pitch_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= flags_d[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frame_roll_r  <= frame_roll_nxt;
      frame_pitch_r <= $signed(ry_d[2*AW-1:AW]);
      heading_r     <= $signed(ry_d[AW-1:0]);
      clamped_r     <= flags_d[1];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_roll    = frame_roll_r;
  assign out_frame_pitch   = frame_pitch_r;
  assign out_heading       = heading_r;
  assign out_pitch_clamped = clamped_r;

endmodule

`default_nettype wire

@@ rtl/qte_front.sv @@
// ----------------------------------------------------------------------------
// qte_front
// Two stages: the nine component products, then the doubled sums that form
// the sine and cosine terms of roll, yaw and pitch.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_front import qte_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [QW-1:0] w,
  input  logic signed [QW-1:0] x,
  input  logic signed [QW-1:0] y,
  input  logic signed [QW-1:0] z,
  output logic                 out_vld,
  output logic signed [PW-1:0] sr,
  output logic signed [PW-1:0] cr,
  output logic signed [PW-1:0] sy,
  output logic signed [PW-1:0] cy,
  output logic signed [PW-1:0] sp
);

  logic signed [2*QW-1:0] wx_r, yz_r, wz_r, xy_r, wy_r, zx_r, xx_r, yy_r, zz_r;
  logic                   v1_r, v2_r;
  logic signed [PW-1:0]   sr_r, cr_r, sy_r, cy_r, sp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= w * x;
      yz_r <= y * z;
      wz_r <= w * z;
      xy_r <= x * y;
      wy_r <= w * y;
      zx_r <= z * x;
      xx_r <= x * x;
      yy_r <= y * y;
      zz_r <= z * z;
      sr_r <= (PW'(wx_r) + PW'(yz_r)) <<< 1;
      sy_r <= (PW'(wz_r) + PW'(xy_r)) <<< 1;
      sp_r <= (PW'(wy_r) - PW'(zx_r)) <<< 1;
      cr_r <= ONE_Q28 - ((PW'(xx_r) + PW'(yy_r)) <<< 1);
      cy_r <= ONE_Q28 - ((PW'(yy_r) + PW'(zz_r)) <<< 1);
    end
  end

  assign out_vld = v2_r;
  assign sr      = sr_r;
  assign cr      = cr_r;
  assign sy      = sy_r;
  assign cy      = cy_r;
  assign sp      = sp_r;

endmodule

`default_nettype wire

@@ rtl/qte_isqrt.sv @@
// ----------------------------------------------------------------------------
// qte_isqrt
// Pitch cosine: squares the pitch sine in partial products, subtracts from
// one and takes the floor square root one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_isqrt import qte_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [PW-1:0] sp_in,
  output logic                 out_vld,
  output logic        [RW-1:0] c_out,
  output logic signed [RW-1:0] sp_out,
  output logic                 clamp_out,
  output logic                 neg_out
);

  localparam logic [SQW-1:0] SQ_ONE = SQW'(1) << (2 * MW);

  logic signed [PW-1:0] mag;
  logic                 clamp;
  logic [HW-1:0]        hi, lo;

  logic                 a_vld_r, a_clamp_r, a_neg_r;
  logic signed [RW-1:0] a_sp_r;
  logic [MW-1:0]        hh_r, hl_r, ll_r;
  logic [SQW-1:0]       s2;

  logic [SQW-1:0]       rem_r   [0:SQRT_STAGES];
  logic [SQW-1:0]       res_r   [0:SQRT_STAGES];
  logic signed [RW-1:0] sp_r    [0:SQRT_STAGES];
  logic                 clamp_r [0:SQRT_STAGES];
  logic                 neg_r   [0:SQRT_STAGES];
  logic                 vld_r   [0:SQRT_STAGES];

  always_comb begin
    mag   = sp_in[PW-1] ? -sp_in : sp_in;
    clamp = (sp_in >= ONE_Q28) || (sp_in <= NEG_ONE_Q28);
    hi    = mag[MW-1:HW];
    lo    = mag[HW-1:0];
    s2    = (SQW'(hh_r) << MW) + (SQW'(hl_r) << (HW + 1)) + SQW'(ll_r);
  end

  // stage a: partial products of the sine magnitude
  // stage b: one minus the square
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r  <= 1'b0;
      vld_r[0] <= 1'b0;
    end else if (en) begin
      a_vld_r  <= in_vld;
      vld_r[0] <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r       <= MW'(hi) * MW'(hi);
      hl_r       <= MW'(hi) * MW'(lo);
      ll_r       <= MW'(lo) * MW'(lo);
      a_sp_r     <= sp_in[RW-1:0];
      a_clamp_r  <= clamp;
      a_neg_r    <= sp_in[PW-1];
      rem_r[0]   <= SQ_ONE - s2;
      res_r[0]   <= '0;
      sp_r[0]    <= a_sp_r;
      clamp_r[0] <= a_clamp_r;
      neg_r[0]   <= a_neg_r;
    end
  end

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_root
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQRT_STAGES - 1 - j));
    logic [SQW-1:0] trial;
    logic           take;

    assign trial = res_r[j] + BIT;
    assign take  = rem_r[j] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (take) begin
          rem_r[j+1] <= rem_r[j] - trial;
          res_r[j+1] <= (res_r[j] >> 1) + BIT;
        end else begin
          rem_r[j+1] <= rem_r[j];
          res_r[j+1] <= res_r[j] >> 1;
        end
        sp_r[j+1]    <= sp_r[j];
        clamp_r[j+1] <= clamp_r[j];
        neg_r[j+1]   <= neg_r[j];
      end
    end
  end

  assign out_vld   = vld_r[SQRT_STAGES];
  assign c_out     = res_r[SQRT_STAGES][RW-1:0];
  assign sp_out    = sp_r[SQRT_STAGES];
  assign clamp_out = clamp_r[SQRT_STAGES];
  assign neg_out   = neg_r[SQRT_STAGES];

endmodule

`default_nettype wire

@@ rtl/qte_cordic.sv @@
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring cordic for atan2: quadrant pre-rotation, one
// iteration per stage, then rounding to Q3.13 with clamp to +-pi.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic import qte_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [CW-1:0] x_in,
  output logic signed [AW-1:0] ang_out
);

  localparam int NIT = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;
  localparam logic [ZW:0] RND_HALF = (ZW + 1)'(65536);

  logic signed [CW-1:0] x_r    [0:NIT];
  logic signed [CW-1:0] y_r    [0:NIT];
  logic signed [ZW-1:0] z_r    [0:NIT];
  logic                 zero_r [0:NIT];

  logic signed [CW-1:0] x_p, y_p;
  logic signed [ZW-1:0] z_p;

  logic                 neg;
  logic [ZW-1:0]        mag;
  logic [ZW:0]          rsum;
  logic [ZW-17:0]       rq;
  logic signed [AW-1:0] lim, ang;
  logic signed [AW-1:0] ang_r;

  // left half plane: turn by a quarter first
  always_comb begin
    x_p = x_in;
    y_p = y_in;
    z_p = '0;
    if (x_in[CW-1]) begin
      if (!y_in[CW-1]) begin
        x_p = y_in;
        y_p = -x_in;
        z_p = HALF_PI_Q30;
      end else begin
        x_p = -y_in;
        y_p = x_in;
        z_p = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x_p;
      y_r[0]    <= y_p;
      z_r[0]    <= z_p;
      zero_r[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  for (genvar i = 0; i < NIT; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN_I = $signed({{(ZW-TW){1'b0}}, atan_q30(i)});
    logic dir;

    assign dir = !y_r[i][CW-1] && (y_r[i] != '0);

    always_ff @(posedge clk) begin
      if (en) begin
        if (dir) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN_I;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN_I;
        end
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  // q30 to q3.13, round half away from zero
  always_comb begin
    neg  = z_r[NIT][ZW-1];
    mag  = neg ? ZW'(-z_r[NIT]) : ZW'(z_r[NIT]);
    rsum = {1'b0, mag} + RND_HALF;
    rq   = rsum[ZW:17];
    lim  = (rq > (ZW - 16)'(PI_Q13)) ? $signed(PI_Q13) : $signed(rq[AW-1:0]);
    ang  = zero_r[NIT] ? '0 : (neg ? -lim : lim);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= ang;
    end
  end

  assign ang_out = ang_r;

endmodule

`default_nettype wire

@@ rtl/qte_delay.sv @@
// ----------------------------------------------------------------------------
// qte_delay
// Fixed-length shift line that keeps side data in step with the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [WIDTH-1:0] d_in,
  output logic [WIDTH-1:0] d_out
);

  logic [WIDTH-1:0] sh_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        sh_r[i] <= '0;
      end
    end else if (en) begin
      sh_r[0] <= d_in;
      for (int i = 1; i < DEPTH; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  assign d_out = sh_r[DEPTH-1];

endmodule

`default_nettype wire
